/* src/safe_filename_checker_defines.svh */
// Assertion macros used by the checker file of the safe file name checker.
`ifndef SAFE_FILENAME_CHECKER_DEFINES_SVH
`define SAFE_FILENAME_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sfc_pkg.sv */
// Types and constants of the safe file name checker.
package sfc_pkg;

  // One name byte with its flags
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_req;
  } sfc_item_t;

  // Verdict for one name
  typedef struct packed {
    logic       safe;
    logic [2:0] reason;
  } sfc_verdict_t;

  // Reason codes
  localparam logic [2:0] REASON_SAFE     = 3'd0;
  localparam logic [2:0] REASON_EMPTY    = 3'd1;
  localparam logic [2:0] REASON_COLON    = 3'd2;
  localparam logic [2:0] REASON_LEAD_SEP = 3'd3;
  localparam logic [2:0] REASON_DOTDOT   = 3'd4;
  localparam logic [2:0] REASON_NO_DOT   = 3'd5;
  localparam logic [2:0] REASON_TRAIL    = 3'd6;
  localparam logic [2:0] REASON_DEVICE   = 3'd7;

  // Special bytes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Base name length bookkeeping
  localparam logic [2:0] BASE_KEEP     = 3'd4;  // bytes held in base_chars
  localparam logic [2:0] BASE_TOO_LONG = 3'd5;  // saturation value
  localparam logic [2:0] BASE_LEN3     = 3'd3;

  // Device base names, first byte in the low bits
  localparam logic [23:0] DEV_CON = {8'h4E, 8'h4F, 8'h43};
  localparam logic [23:0] DEV_PRN = {8'h4E, 8'h52, 8'h50};
  localparam logic [23:0] DEV_AUX = {8'h58, 8'h55, 8'h41};
  localparam logic [23:0] DEV_NUL = {8'h4C, 8'h55, 8'h4E};
  localparam logic [23:0] DEV_COM = {8'h4D, 8'h4F, 8'h43};
  localparam logic [23:0] DEV_LPT = {8'h54, 8'h50, 8'h4C};

endpackage

/* src/sfc_name_state.sv */
// Per-name flag state, byte update and verdict logic.
module sfc_name_state
  import sfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,     // item leaves the input register this cycle
  input  sfc_item_t    item,
  output sfc_verdict_t verdict   // valid when item.end_req
);

  logic        started, seen_colon, leading_sep, seen_dotdot;
  logic        seen_dot, prev_dot, last_dot_or_space, base_closed;
  logic [31:0] base_chars;
  logic [2:0]  base_len;

  logic        started_next, seen_colon_next, leading_sep_next, seen_dotdot_next;
  logic        seen_dot_next, prev_dot_next, last_dot_or_space_next, base_closed_next;
  logic [31:0] base_chars_next;
  logic [2:0]  base_len_next;

  logic        sep, dot;
  logic [7:0]  upper;
  logic [4:0]  slot;
  logic [7:0]  digit;
  logic        is_device;
  logic [2:0]  reason;

  // Byte classification
  assign sep   = (item.ch == CH_SLASH) || (item.ch == CH_BSLASH);
  assign dot   = (item.ch == CH_DOT);
  assign upper = ((item.ch >= CH_LOW_A) && (item.ch <= CH_LOW_Z)) ?
                 (item.ch - CASE_OFFSET) : item.ch;
  assign slot  = {base_len[1:0], 3'b000};

  // State after taking this item's byte
  always_comb begin
    started_next           = started;
    seen_colon_next        = seen_colon;
    leading_sep_next       = leading_sep;
    seen_dotdot_next       = seen_dotdot;
    seen_dot_next          = seen_dot;
    prev_dot_next          = prev_dot;
    last_dot_or_space_next = last_dot_or_space;
    base_closed_next       = base_closed;
    base_chars_next        = base_chars;
    base_len_next          = base_len;
    if (item.has_char) begin
      if (!started) begin
        leading_sep_next = sep;
      end
      started_next = 1'b1;
      if (item.ch == CH_COLON) begin
        seen_colon_next = 1'b1;
      end
      if (dot) begin
        if (prev_dot) begin
          seen_dotdot_next = 1'b1;
        end
        seen_dot_next = 1'b1;
      end
      prev_dot_next          = dot;
      last_dot_or_space_next = dot || (item.ch == CH_SPACE);
      if (sep) begin
        base_chars_next  = '0;
        base_len_next    = '0;
        base_closed_next = 1'b0;
      end else if (!base_closed) begin
        if (dot) begin
          base_closed_next = 1'b1;
        end else begin
          if (base_len < BASE_KEEP) begin
            base_chars_next[slot +: 8] = base_chars[slot +: 8] | upper;
          end
          if (base_len < BASE_TOO_LONG) begin
            base_len_next = base_len + 3'd1;
          end
        end
      end
    end
  end

  // Reserved device base name
  assign digit = base_chars_next[31:24];
  always_comb begin
    is_device = 1'b0;
    if (base_len_next == BASE_LEN3) begin
      is_device = (base_chars_next[23:0] == DEV_CON) || (base_chars_next[23:0] == DEV_PRN) ||
                  (base_chars_next[23:0] == DEV_AUX) || (base_chars_next[23:0] == DEV_NUL);
    end else if (base_len_next == BASE_KEEP) begin
      is_device = (digit >= CH_ONE) && (digit <= CH_NINE) &&
                  ((base_chars_next[23:0] == DEV_COM) || (base_chars_next[23:0] == DEV_LPT));
    end
  end

  // Checks in priority order
  always_comb begin
    priority if (!started_next)         reason = REASON_EMPTY;
    else if (seen_colon_next)           reason = REASON_COLON;
    else if (leading_sep_next)          reason = REASON_LEAD_SEP;
    else if (seen_dotdot_next)          reason = REASON_DOTDOT;
    else if (!seen_dot_next)            reason = REASON_NO_DOT;
    else if (last_dot_or_space_next)    reason = REASON_TRAIL;
    else if (is_device)                 reason = REASON_DEVICE;
    else                                reason = REASON_SAFE;
  end

  assign verdict.reason = reason;
  assign verdict.safe   = (reason == REASON_SAFE);

  // State registers; a verdict clears them for the next name
  always_ff @(posedge clk) begin
    if (rst || (step && item.end_req)) begin
      started           <= 1'b0;
      seen_colon        <= 1'b0;
      leading_sep       <= 1'b0;
      seen_dotdot       <= 1'b0;
      seen_dot          <= 1'b0;
      prev_dot          <= 1'b0;
      last_dot_or_space <= 1'b0;
      base_closed       <= 1'b0;
      base_chars        <= '0;
      base_len          <= '0;
    end else if (step) begin
      started           <= started_next;
      seen_colon        <= seen_colon_next;
      leading_sep       <= leading_sep_next;
      seen_dotdot       <= seen_dotdot_next;
      seen_dot          <= seen_dot_next;
      prev_dot          <= prev_dot_next;
      last_dot_or_space <= last_dot_or_space_next;
      base_closed       <= base_closed_next;
      base_chars        <= base_chars_next;
      base_len          <= base_len_next;
    end
  end

endmodule

/* src/safe_filename_checker.sv */
// Top level of the safe file name checker: input register, name state, result register.
// The verdict, formed combinationally from the input register, enters the result register when the end item steps.
// Throughput: one byte transfer per cycle unless an end item is stalled; the name state updates once per byte.
// Stalls: only an end item waits on a full, unread result register.
// Reset: rst (synchronous, active high) empties both registers and clears the name state.
module safe_filename_checker
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tuser,   // [0] has_char
  input  logic       s_axis_tlast,   // end_req
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] safe, [3:1] reason, [7:4] zero
);

  logic         in_valid;
  sfc_item_t    in_item;
  logic         out_valid;
  sfc_verdict_t out_verdict;
  logic         out_free;
  logic         step;
  sfc_verdict_t verdict;

  // Handshake control
  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && (!in_item.end_req || out_free);
  assign s_axis_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.ch       <= s_axis_tdata;
      in_item.has_char <= s_axis_tuser;
      in_item.end_req  <= s_axis_tlast;
    end
  end

  sfc_name_state u_state (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (in_item),
    .verdict (verdict)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_item.end_req) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_item.end_req) begin
      out_verdict <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_verdict.reason, out_verdict.safe};

endmodule

/* src/sfc_checker.sv */
// Port-level assertions for the safe file name checker, bound to the top level.
`include "safe_filename_checker_defines.svh"

module sfc_checker
  import sfc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tuser,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled verdict holds
  `SFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "verdict changed while stalled")

  // safe is set exactly for the safe reason code
  `SFC_ASSERT_NOW(a_safe_code, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[3:1] == REASON_SAFE), "safe flag disagrees with reason")

  // Padding bits stay zero
  `SFC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:4] == 4'b0000, "nonzero padding in verdict")

endmodule

bind safe_filename_checker sfc_checker u_sfc_checker (.*);

/* test/tb_safe_filename_checker.sv */
// Self-checking testbench for the safe file name checker stream block.
`timescale 1ns / 1ps

module tb_safe_filename_checker;
  import sfc_pkg::*;

  typedef logic [7:0] name_q_t[$];

  // Clock, reset and stream signals
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] ch
  logic       s_axis_tuser = 1'b0;    // [0] has_char
  logic       s_axis_tlast = 1'b0;    // end_req
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] safe, [3:1] reason, [7:4] zero

  // Phase controls and bookkeeping
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int err_cnt = 0;
  int items_sent = 0;
  sfc_verdict_t expected_verdicts[$];

  // Predicted name state
  logic        nm_started;
  logic        nm_colon;
  logic        nm_lead_sep;
  logic        nm_dotdot;
  logic        nm_dot;
  logic        nm_prev_dot;
  logic        nm_trail;
  logic [31:0] nm_base;
  logic [2:0]  nm_base_len;
  logic        nm_base_closed;

  safe_filename_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Name state predictor
  // ---------------------------------------------------------------------------
  task automatic clear_name();
    nm_started     = 1'b0;
    nm_colon       = 1'b0;
    nm_lead_sep    = 1'b0;
    nm_dotdot      = 1'b0;
    nm_dot         = 1'b0;
    nm_prev_dot    = 1'b0;
    nm_trail       = 1'b0;
    nm_base        = '0;
    nm_base_len    = '0;
    nm_base_closed = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] c);
    logic       is_sep;
    logic       is_dot;
    logic [7:0] up;
    is_sep = (c == CH_SLASH) || (c == CH_BSLASH);
    is_dot = (c == CH_DOT);
    if (!nm_started) begin
      nm_lead_sep = is_sep;
      nm_started  = 1'b1;
    end
    if (c == CH_COLON) nm_colon = 1'b1;
    if (is_dot) begin
      if (nm_prev_dot) nm_dotdot = 1'b1;
      nm_dot = 1'b1;
    end
    nm_prev_dot = is_dot;
    nm_trail    = is_dot || (c == CH_SPACE);
    // a separator restarts the base name; a dot closes it
    if (is_sep) begin
      nm_base        = '0;
      nm_base_len    = '0;
      nm_base_closed = 1'b0;
    end else if (!nm_base_closed) begin
      if (is_dot) begin
        nm_base_closed = 1'b1;
      end else begin
        up = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) up = c - CASE_OFFSET;
        if (nm_base_len < BASE_KEEP) nm_base[nm_base_len*8 +: 8] = up;
        if (nm_base_len < BASE_TOO_LONG) nm_base_len = nm_base_len + 3'd1;
      end
    end
  endtask

  function automatic logic is_device_base();
    logic [23:0] head;
    logic [7:0]  digit;
    head  = nm_base[23:0];
    digit = nm_base[31:24];
    if (nm_base_len == BASE_LEN3)
      return head == DEV_CON || head == DEV_PRN || head == DEV_AUX || head == DEV_NUL;
    if (nm_base_len == BASE_KEEP)
      return digit >= CH_ONE && digit <= CH_NINE && (head == DEV_COM || head == DEV_LPT);
    return 1'b0;
  endfunction

  function automatic logic [2:0] name_reason();
    if (!nm_started)     return REASON_EMPTY;
    if (nm_colon)        return REASON_COLON;
    if (nm_lead_sep)     return REASON_LEAD_SEP;
    if (nm_dotdot)       return REASON_DOTDOT;
    if (!nm_dot)         return REASON_NO_DOT;
    if (nm_trail)        return REASON_TRAIL;
    if (is_device_base()) return REASON_DEVICE;
    return REASON_SAFE;
  endfunction

  task automatic predict_transfer(input logic [7:0] c, input logic has, input logic last);
    sfc_verdict_t v;
    if (has) absorb_byte(c);
    if (last) begin
      v.reason = name_reason();
      v.safe   = (v.reason == REASON_SAFE);
      expected_verdicts.push_back(v);
      clear_name();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item per call, called at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] c, input logic has, input logic last);
    int gap;
    gap = src_idle_en ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_transfer(c, has, last);
    if (has || last) items_sent++;
  endtask

  // Sends a name; ends on its last byte or with a separate end marker.
  // Ignored items (no byte, no end) are scattered in now and then.
  task automatic send_name(input name_q_t nm, input bit end_on_byte);
    for (int i = 0; i < nm.size(); i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(nm[i], 1'b1, end_on_byte && (i == nm.size() - 1));
    end
    if (nm.size() == 0 || !end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Name builders
  // ---------------------------------------------------------------------------
  function automatic name_q_t str_name(input string s);
    name_q_t nm;
    for (int i = 0; i < s.len(); i++) nm.push_back(s[i]);
    return nm;
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 5) return CH_LOW_A + 8'($urandom_range(0, 25));
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_sep();
    return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
  endfunction

  function automatic name_q_t plain_name();
    name_q_t nm;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) nm.push_back(rand_letter());
      nm.push_back(rand_sep());
    end
    repeat ($urandom_range(1, 6)) nm.push_back(rand_letter());
    nm.push_back(CH_DOT);
    repeat ($urandom_range(1, 3)) nm.push_back(rand_letter());
    return nm;
  endfunction

  function automatic name_q_t device_name();
    name_q_t     nm;
    logic [23:0] word;
    logic        numbered;
    case ($urandom_range(0, 5))
      0: word = DEV_CON;
      1: word = DEV_PRN;
      2: word = DEV_AUX;
      3: word = DEV_NUL;
      4: word = DEV_COM;
      default: word = DEV_LPT;
    endcase
    numbered = (word == DEV_COM) || (word == DEV_LPT);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) nm.push_back(rand_letter());
      nm.push_back(rand_sep());
    end
    // random letter case on each byte
    for (int k = 0; k < 3; k++)
      nm.push_back(word[k*8 +: 8] | ($urandom_range(0, 1) ? CASE_OFFSET : 8'h00));
    if (numbered || $urandom_range(0, 4) == 0)
      nm.push_back($urandom_range(0, 5) == 0 ? rand_letter() :
                   8'h30 + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 5))
      0: ;
      1: nm.push_back(CH_DOT);
      2: begin
        nm.push_back(rand_letter());
        nm.push_back(CH_DOT);
        nm.push_back(rand_letter());
      end
      default: begin
        nm.push_back(CH_DOT);
        repeat ($urandom_range(1, 3)) nm.push_back(rand_letter());
      end
    endcase
    return nm;
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 9))
      0: return CH_DOT;
      1: return CH_SPACE;
      2: return CH_COLON;
      3: return CH_SLASH;
      4: return CH_BSLASH;
      5: return CH_DOT;
      6: return 8'h00;
      7: return 8'hFF;
      default: return rand_letter();
    endcase
  endfunction

  // Mostly well-formed names; the rest broken or pure noise
  function automatic name_q_t random_name();
    name_q_t nm;
    int      pos;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: nm = plain_name();
      4, 5: nm = device_name();
      6: repeat ($urandom_range(0, 8)) nm.push_back(8'($urandom_range(0, 255)));
      7: repeat ($urandom_range(1, 8)) nm.push_back(special_byte());
      default: begin
        nm  = $urandom_range(0, 1) ? plain_name() : device_name();
        pos = $urandom_range(0, nm.size());
        case ($urandom_range(0, 4))
          0: nm.insert(pos, CH_COLON);
          1: begin
            nm.insert(pos, CH_DOT);
            nm.insert(pos, CH_DOT);
          end
          2: nm.push_front(rand_sep());
          3: nm.push_back($urandom_range(0, 1) ? CH_DOT : CH_SPACE);
          default: nm.insert(pos, rand_sep());
        endcase
      end
    endcase
    return nm;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checker
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      gap = snk_idle_en ? gap_len() : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sfc_verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("verdict transfer with none expected: tdata=%h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.safe) begin
          $error("safe: expected %0d, got %0d", want.safe, m_axis_tdata[0]);
          err_cnt++;
        end
        if (m_axis_tdata[3:1] !== want.reason) begin
          $error("reason: expected %0d, got %0d", want.reason, m_axis_tdata[3:1]);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    name_q_t nm;
    send_name(nm, 1'b0);                         // empty name
    send_name(str_name("a:b.txt"), 1'b1);
    send_name(str_name("/a.txt"), 1'b1);
    send_name(str_name("\\b.txt"), 1'b0);
    send_name(str_name("a..b"), 1'b1);
    send_name(str_name("readme"), 1'b1);
    send_name(str_name("file."), 1'b1);
    send_name(str_name("file.txt "), 1'b0);
    send_name(str_name("CON.txt"), 1'b1);
    send_name(str_name("nul.c"), 1'b0);
    send_name(str_name("Com1.log"), 1'b1);
    send_name(str_name("lpt9.x"), 1'b1);
    send_name(str_name("aUx.h"), 1'b1);
    send_name(str_name("com0.x"), 1'b1);         // digit out of range
    send_name(str_name("con1.x"), 1'b1);         // four bytes, not COM or LPT
    send_name(str_name("console.t"), 1'b1);      // too long to match
    send_name(str_name("dir/NUL.txt"), 1'b1);    // base after the separator
    send_name(str_name("d\\a.b"), 1'b0);
    // zero byte and top-bit byte taken as ordinary bytes
    nm = {8'h43, 8'h00, 8'h4E, CH_DOT, 8'h74};
    send_name(nm, 1'b1);
    nm = {8'hFF, CH_DOT, 8'hA5};
    send_name(nm, 1'b1);
    // ignored item inside a name, then end marker after the bytes
    send_item(8'h2E, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_names(input int n_items);
    int stop;
    stop = items_sent + n_items;
    while (items_sent < stop) send_name(random_name(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_full_rate(input int n_items);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random_names(n_items);
    snk_idle_en = 1'b1;
    test_random_names(n_items);
    src_idle_en = 1'b1;
  endtask

  initial begin
    clear_name();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_names(900);
    test_full_rate(150);
    // drop valid at the edge of the last transfer so it is not taken twice
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* safe_filename_checker.f */
+incdir+src
src/sfc_pkg.sv
src/sfc_name_state.sv
src/safe_filename_checker.sv
src/sfc_checker.sv
test/tb_safe_filename_checker.sv
